>>> rtl/core/pfb8_pkg.sv
// ----------------------------------------------------------------------------
// Pixel format to BGRA8 package
// Format codes, channel helpers and the sRGB threshold table for half floats.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb8_pkg;

    localparam logic [1:0] FMT_BGRA8   = 2'd0;
    localparam logic [1:0] FMT_RGB10A2 = 2'd1;
    localparam logic [1:0] FMT_RGBA16F = 2'd2;
    localparam logic [1:0] FMT_RGBA8   = 2'd3;

    localparam int unsigned NUM_CHAN   = 3;
    localparam int unsigned SRCH_STEPS = 8;
    localparam logic [14:0] HALF_INF   = 15'h7C00;

    typedef logic [14:0] t_thr_tab [256];

    // Rounds a 10-bit channel to 8 bits: floor((v*255 + 511) / 1023).
    // The quotient by 1023 is x>>10 plus one correction step.
    function automatic logic [7:0] ten_to_byte(input logic [9:0] v);
        logic [17:0] x;
        logic [7:0]  q0;
        logic [10:0] rem;
        x   = 18'(v) * 18'd255 + 18'd511;
        q0  = x[17:10];
        rem = 11'(x[9:0]) + 11'(q0);
        return (rem >= 11'd1023) ? q0 + 8'd1 : q0;
    endfunction

    // Negative values and NaNs map to code 0, which lies below every threshold but that of byte 0.
    function automatic logic [14:0] half_key(input logic [15:0] h);
        logic is_nan;
        is_nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        return (h[15] || is_nan) ? 15'd0 : h[14:0];
    endfunction

    // True when the tone-mapped, sRGB-encoded byte of half code h is at least lvl.
    function automatic logic byte_ge(input logic [14:0] h, input int unsigned lvl);
        logic [4:0]   e;
        logic [9:0]   f;
        logic [63:0]  a;
        logic [63:0]  bd;
        logic [63:0]  s;
        logic [63:0]  c;
        logic [351:0] lhs;
        logic [351:0] rhs;
        e = h[14:10];
        f = h[9:0];
        if (e == 5'd0) begin
            a  = 64'(f);
            bd = 64'd1 << 24;
        end else if (e >= 5'd25) begin
            a  = 64'({1'b1, f}) << (e - 5'd25);
            bd = 64'd1;
        end else begin
            a  = 64'({1'b1, f});
            bd = 64'd1 << (5'd25 - e);
        end
        if (a == 64'd0) begin
            return 1'b0;
        end
        s = a + bd;
        if (a * 64'd10000000 <= 64'd31308 * s) begin
            return (a * 64'd32946 + 64'd5 * s) >= (64'd10 * s * 64'(lvl));
        end
        c   = 64'(200 * lvl + 2705);
        lhs = 352'd1;
        rhs = 352'd1;
        for (int i = 0; i < 5; i++) begin
            lhs = lhs * 352'(a);
            rhs = rhs * 352'(s);
        end
        for (int i = 0; i < 12; i++) begin
            lhs = lhs * 352'd53805;
            rhs = rhs * 352'(c);
        end
        return lhs >= rhs;
    endfunction

    // Entry b from 1 up holds the smallest positive half code whose byte is at least b; entry 0 is 0.
    function automatic t_thr_tab build_thr();
        t_thr_tab    t;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        t[0] = 15'd0;
        for (int unsigned b = 1; b < 256; b++) begin
            lo = 1;
            hi = 32'(HALF_INF);
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (byte_ge(15'(mid), b)) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            t[b] = 15'(lo);
        end
        return t;
    endfunction

    localparam t_thr_tab SRGB_THR = build_thr();

endpackage

`default_nettype wire

>>> rtl/core/pixel_format_to_bgra8_unit.sv
// ----------------------------------------------------------------------------
// Pixel format to BGRA8 unit
// Converts one BGRA8, R10G10B10A2, RGBA16F or RGBA8 pixel per transfer into
// one BGRA8 pixel; half floats are tone-mapped and sRGB-encoded.
// ----------------------------------------------------------------------------
//
// Channel   | Direction | Payload
// ----------+-----------+-----------------------------------------------
// s (in)    | slave     | tdata: pixel_low, pixel_high; tlast: last_in_frame
// m (out)   | master    | tdata: blue, green, red, alpha; tlast: frame_end
// cfg       | write     | wdata: pixel_format
//
// The pipeline accepts one pixel per cycle while the output is not held and has
// nine register stages. A pixel enters stage 0 at its transfer and passes through
// stages 1 to 8 to the output register, stage 8.
// The depth is set by the eight-step binary search of the sRGB threshold
// table, one step per stage and per channel.
// Reset (i_rst_n low, synchronous) clears all valid bits and the format.
// When the output is held, every stage holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_to_bgra8_unit
    import pfb8_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,   // pixel_format
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,     // [31:0] pixel_low, [63:32] pixel_high
    input  wire logic        i_s_tlast,     // last_in_frame
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,     // [7:0] blue, [15:8] green,
                                            // [23:16] red, [31:24] alpha
    output logic             o_m_tlast      // frame_end
);

    localparam int unsigned LAST = SRCH_STEPS;

    logic [1:0]  r_fmt;

    // Stage 0 holds the decoded pixel; stages 1 to 8 each settle one result
    // bit of the half-float search. Stage 8 is the output register.
    logic        r_vld   [0:LAST];
    logic        r_half  [0:LAST];
    logic        r_last  [0:LAST];
    logic [7:0]  r_alpha [0:LAST];
    logic [14:0] r_key   [0:LAST][0:NUM_CHAN-1];
    logic [7:0]  r_acc   [0:LAST][0:NUM_CHAN-1];

    logic        w_adv;
    logic [7:0]  n_acc   [0:NUM_CHAN-1];
    logic [14:0] n_key   [0:NUM_CHAN-1];
    logic [7:0]  n_alpha;
    logic [31:0] w_lo;
    logic [31:0] w_hi;

    // The whole pipeline moves whenever the output register is free or drained.
    assign w_adv      = !r_vld[LAST] || i_m_tready;
    assign o_s_tready = w_adv;
    assign w_lo       = i_s_tdata[31:0];
    assign w_hi       = i_s_tdata[63:32];

    // Channel order in the arrays is blue, green, red.
    always_comb begin
        n_key[0] = half_key(w_hi[15:0]);
        n_key[1] = half_key(w_lo[31:16]);
        n_key[2] = half_key(w_lo[15:0]);
        n_alpha  = 8'hFF;
        case (r_fmt)
            FMT_BGRA8: begin
                n_acc[0] = w_lo[7:0];
                n_acc[1] = w_lo[15:8];
                n_acc[2] = w_lo[23:16];
                n_alpha  = w_lo[31:24];
            end
            FMT_RGB10A2: begin
                n_acc[0] = ten_to_byte(w_lo[29:20]);
                n_acc[1] = ten_to_byte(w_lo[19:10]);
                n_acc[2] = ten_to_byte(w_lo[9:0]);
            end
            FMT_RGBA16F: begin
                // The search starts from zero and builds the byte bit by bit.
                n_acc[0] = 8'd0;
                n_acc[1] = 8'd0;
                n_acc[2] = 8'd0;
            end
            default: begin
                n_acc[0] = w_lo[23:16];
                n_acc[1] = w_lo[15:8];
                n_acc[2] = w_lo[7:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_BGRA8;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_half[0]  <= (r_fmt == FMT_RGBA16F);
            r_last[0]  <= i_s_tlast;
            r_alpha[0] <= n_alpha;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_key[0][c] <= n_key[c];
                r_acc[0][c] <= n_acc[c];
            end
            for (int k = 1; k <= LAST; k++) begin
                r_half[k]  <= r_half[k-1];
                r_last[k]  <= r_last[k-1];
                r_alpha[k] <= r_alpha[k-1];
                for (int c = 0; c < NUM_CHAN; c++) begin
                    r_key[k][c] <= r_key[k-1][c];
                    // Try the next lower result bit; keep it if the table
                    // entry for that byte is not above the key.
                    if (r_half[k-1] &&
                        SRGB_THR[r_acc[k-1][c] | (8'h80 >> (k - 1))] <= r_key[k-1][c]) begin
                        r_acc[k][c] <= r_acc[k-1][c] | (8'h80 >> (k - 1));
                    end else begin
                        r_acc[k][c] <= r_acc[k-1][c];
                    end
                end
            end
        end
    end

    assign o_m_tvalid = r_vld[LAST];
    assign o_m_tlast  = r_last[LAST];
    assign o_m_tdata  = {r_alpha[LAST], r_acc[LAST][2], r_acc[LAST][1], r_acc[LAST][0]};

`ifndef ASSERT_OFF
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow the output stage");

    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !r_half[LAST] && r_fmt != FMT_BGRA8 |-> o_m_tdata[31:24] == 8'hFF)
        else $error("alpha not opaque outside the copy format");

    a_half_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_half[LAST] |-> o_m_tdata[31:24] == 8'hFF)
        else $error("half-float pixel lost its opaque alpha");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output pixel changed during a stall");
`endif

endmodule

`default_nettype wire

>>> tb/pixel_format_to_bgra8_unit_test.sv
// ----------------------------------------------------------------------------
// Pixel format to BGRA8 unit testbench
// Sends pixels in all four source formats through the unit while both stream
// sides idle at random. A local predictor derives every expected BGRA8 pixel,
// including the exact tone-mapped sRGB bytes of half floats, and the results
// are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_format_to_bgra8_unit_test;
    import pfb8_pkg::*;

    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        last;
    } t_src_pixel;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       frame_end;
    } t_bgra_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = FMT_BGRA8;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;

    pixel_format_to_bgra8_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // [31:0] pixel_low, [63:32] pixel_high
        .i_s_tlast   (i_s_tlast),    // last_in_frame
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),    // [7:0] blue, [15:8] green, [23:16] red, [31:24] alpha
        .o_m_tlast   (o_m_tlast)     // frame_end
    );

    always #4 i_clk = ~i_clk;

    // Pixels waiting to be offered, and converted pixels waiting to arrive.
    t_src_pixel  pending_pixels[$];
    t_bgra_pixel awaited_pixels[$];
    logic [1:0]  fmt_now = FMT_BGRA8;
    bit          idle_enable = 1'b1;
    int unsigned mismatches = 0;
    int unsigned pixels_seen = 0;
    int unsigned formats_used = 0;

    // Idle length: mostly none, sometimes short, now and then long.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // True when (a/s)^5 >= ((200*lvl + 2705)/53805)^12, i.e. the power segment
    // of the sRGB curve rounds to at least lvl. Done in wide integers.
    function automatic bit srgb_reaches(longint unsigned a, longint unsigned s,
                                        int unsigned lvl);
        logic [383:0] lhs;
        logic [383:0] rhs;
        logic [383:0] step;
        lhs  = 384'd1;
        rhs  = 384'd1;
        step = 384'(200 * lvl + 2705);
        repeat (5) begin
            lhs = lhs * 384'(a);
            rhs = rhs * 384'(s);
        end
        repeat (12) begin
            lhs = lhs * 384'd53805;
            rhs = rhs * step;
        end
        return lhs >= rhs;
    endfunction

    // One half-float channel, tone-mapped by x/(1+x) and sRGB-encoded.
    function automatic logic [7:0] half_to_srgb(logic [15:0] h);
        logic [4:0]      ex;
        logic [9:0]      man;
        longint unsigned num;
        longint unsigned den;
        longint unsigned tot;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        ex  = h[14:10];
        man = h[9:0];
        // Anything negative, including minus zero and negative NaN, is black.
        if (h[15]) begin
            return 8'd0;
        end
        // Infinity saturates; a NaN is treated as black.
        if (ex == 5'd31) begin
            return (man != 10'd0) ? 8'd0 : 8'd255;
        end
        if (ex == 5'd0) begin
            num = man;
            den = 64'd1 << 24;
        end else if (ex >= 5'd25) begin
            num = {1'b1, man} << (ex - 5'd25);
            den = 1;
        end else begin
            num = {1'b1, man};
            den = 64'd1 << (25 - ex);
        end
        if (num == 0) begin
            return 8'd0;
        end
        tot = num + den;
        // Linear segment near black.
        if (num * 64'd10000000 <= 64'd31308 * tot) begin
            return 8'((num * 64'd32946 + 64'd5 * tot) / (64'd10 * tot));
        end
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (srgb_reaches(num, tot, mid)) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return 8'(lo);
    endfunction

    function automatic logic [7:0] ten_bit_to_byte(logic [9:0] v);
        return 8'((32'(v) * 255 + 511) / 1023);
    endfunction

    function automatic t_bgra_pixel convert_pixel(t_src_pixel p, logic [1:0] fmt);
        t_bgra_pixel q;
        q.frame_end = p.last;
        q.alpha     = 8'hFF;
        case (fmt)
            FMT_BGRA8: begin
                {q.alpha, q.red, q.green, q.blue} = p.lo;
            end
            FMT_RGB10A2: begin
                q.red   = ten_bit_to_byte(p.lo[9:0]);
                q.green = ten_bit_to_byte(p.lo[19:10]);
                q.blue  = ten_bit_to_byte(p.lo[29:20]);
            end
            FMT_RGBA16F: begin
                q.red   = half_to_srgb(p.lo[15:0]);
                q.green = half_to_srgb(p.lo[31:16]);
                q.blue  = half_to_srgb(p.hi[15:0]);
            end
            default: begin
                q.red   = p.lo[7:0];
                q.green = p.lo[15:8];
                q.blue  = p.lo[23:16];
            end
        endcase
        return q;
    endfunction

    // Driver: the expectation is formed at the edge where the transfer happens,
    // then the next pixel (or an idle cycle) is put on the bus.
    int unsigned src_gap = 0;
    always @(posedge i_clk) begin
        t_src_pixel nxt;
        logic       nxt_valid;
        if (i_s_tvalid && o_s_tready) begin
            awaited_pixels.push_back(convert_pixel('{i_s_tdata[31:0], i_s_tdata[63:32],
                                                    i_s_tlast}, fmt_now));
        end
        nxt_valid = i_s_tvalid && !o_s_tready;
        if (i_rst_n && !nxt_valid) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
            end else if (pending_pixels.size() > 0) begin
                nxt = pending_pixels.pop_front();
                i_s_tdata <= {nxt.hi, nxt.lo};
                i_s_tlast <= nxt.last;
                nxt_valid = 1'b1;
                if (idle_enable) begin
                    src_gap <= gap_len();
                end
            end
        end
        i_s_tvalid <= nxt_valid;
    end

    // Monitor: checks each output transfer and drives back-pressure. Once,
    // after a few hundred pixels, the receiver holds off for a long stretch so
    // that the pipeline fills and stalls its input.
    int unsigned sink_gap = 0;
    bit          long_hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_bgra_pixel exp_px;
        if (o_m_tvalid && i_m_tready) begin
            pixels_seen++;
            if (awaited_pixels.size() == 0) begin
                $error("unexpected output pixel %h", o_m_tdata);
                mismatches++;
            end else begin
                exp_px = awaited_pixels.pop_front();
                if (o_m_tdata[7:0] !== exp_px.blue) begin
                    $error("blue: expected %0d, got %0d", exp_px.blue, o_m_tdata[7:0]);
                    mismatches++;
                end
                if (o_m_tdata[15:8] !== exp_px.green) begin
                    $error("green: expected %0d, got %0d", exp_px.green, o_m_tdata[15:8]);
                    mismatches++;
                end
                if (o_m_tdata[23:16] !== exp_px.red) begin
                    $error("red: expected %0d, got %0d", exp_px.red, o_m_tdata[23:16]);
                    mismatches++;
                end
                if (o_m_tdata[31:24] !== exp_px.alpha) begin
                    $error("alpha: expected %0d, got %0d", exp_px.alpha, o_m_tdata[31:24]);
                    mismatches++;
                end
                if (o_m_tlast !== exp_px.frame_end) begin
                    $error("frame_end: expected %0d, got %0d", exp_px.frame_end, o_m_tlast);
                    mismatches++;
                end
            end
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (!long_hold_done && pixels_seen >= 300) begin
            long_hold_done <= 1'b1;
            sink_gap       <= 80;
            i_m_tready     <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap   <= sink_gap - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (idle_enable) begin
                sink_gap <= gap_len();
            end
        end
    end

    // Half-float channel values, weighted towards the interesting corners.
    function automatic logic [15:0] pick_half();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(0, 11))
            0: h[14:10] = 5'd31;                         // infinities and NaNs
            1: h[14:10] = 5'd0;                          // subnormals and zero
            2: h[14:0] = 15'h7C00;
            3: h[14:10] = 5'($urandom_range(0, 8));      // small values, around the linear knee
            default: h[15] = ($urandom_range(0, 5) == 0);
        endcase
        return h;
    endfunction

    task automatic queue_pixel(logic [31:0] lo, logic [31:0] hi);
        pending_pixels.push_back('{lo, hi, ($urandom_range(0, 15) == 0)});
    endtask

    // The bus is looked at on the falling edge, when the driver's updates
    // from the rising edge have settled.
    task automatic drain_and_settle();
        while (pending_pixels.size() > 0 || i_s_tvalid || awaited_pixels.size() > 0) begin
            @(negedge i_clk);
        end
        // Nine pipeline stages; leave a margin.
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_format(logic [1:0] fmt);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fmt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fmt_now = fmt;
        formats_used++;
    endtask

    task automatic queue_directed(logic [1:0] fmt);
        case (fmt)
            FMT_RGB10A2: begin
                queue_pixel(32'h0000_0000, 32'h0);
                queue_pixel(32'hFFFF_FFFF, 32'h0);
                queue_pixel({2'b00, 10'd512, 10'd511, 10'd1}, 32'h0);
                queue_pixel({2'b11, 10'd2, 10'd1022, 10'd1023}, 32'h0);
            end
            FMT_RGBA16F: begin
                // Zero and minus zero, infinities, NaNs, smallest subnormal,
                // largest finite, one, and values around the linear knee.
                queue_pixel({16'h8000, 16'h0000}, {16'h1234, 16'h7C00});
                queue_pixel({16'h7E00, 16'hFC00}, {16'hFFFF, 16'hFE01});
                queue_pixel({16'h7BFF, 16'h0001}, {16'h0000, 16'h3C00});
                queue_pixel({16'h1A6B, 16'h1A6A}, {16'h0000, 16'h1A6C});
                queue_pixel({16'h03FF, 16'h0400}, {16'h0000, 16'h7BFE});
                queue_pixel({16'h7FFF, 16'h7C01}, {16'hFFFF, 16'hFBFF});
            end
            default: begin
                queue_pixel(32'h0000_0000, 32'hFFFF_FFFF);
                queue_pixel(32'hFFFF_FFFF, 32'h0000_0000);
                queue_pixel(32'h80FF_0001, 32'h0);
                queue_pixel(32'h7F00_FF80, 32'h0);
            end
        endcase
        pending_pixels[pending_pixels.size() - 1].last = 1'b1;
    endtask

    initial begin : stimulus
        logic [1:0]  plan[10];
        int unsigned count;
        plan = '{FMT_BGRA8, FMT_RGB10A2, FMT_RGBA16F, FMT_RGBA8, FMT_RGBA16F,
                 FMT_RGB10A2, FMT_BGRA8, FMT_RGBA8, FMT_RGBA16F, FMT_BGRA8};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        for (int ph = 0; ph < 10; ph++) begin
            // The first phase checks the format after reset without a write.
            if (ph > 0) begin
                set_format(plan[ph]);
            end
            idle_enable = (ph % 4 != 3);
            queue_directed(plan[ph]);
            count = (plan[ph] == FMT_RGBA16F) ? 220 : 140;
            for (int n = 0; n < count; n++) begin
                if (plan[ph] == FMT_RGBA16F) begin
                    queue_pixel({pick_half(), pick_half()}, {16'($urandom), pick_half()});
                end else begin
                    queue_pixel($urandom, $urandom);
                end
            end
            // The sender pauses here until every converted pixel is back.
            drain_and_settle();
        end
        $display("Checked %0d pixels across %0d format changes, all four formats,",
                 pixels_seen, formats_used);
        $display("with random idling on both sides and one long output stall.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
